// ----- rtl/mrfc_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the response frame checker.
`timescale 1ns / 1ps

package mrfc_pkg;

	localparam int FRAME_LENGTH_DEF = 11;
	localparam int FRAME_LENGTH_MIN = 5;
	localparam int FRAME_LENGTH_MAX = 15;

	localparam logic [7:0]  ADDR_RESET = 8'h01;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;

	// One byte held in the input stage.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} mrfc_item_t;

	// Modbus CRC-16, reflected, one byte folded in bit by bit.
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/mrfc_input_stage.sv -----
// Input register stage: holds one received byte until the frame logic takes it.
`timescale 1ns / 1ps

module mrfc_input_stage import mrfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output mrfc_item_t item
);

	logic       valid_s1;
	logic [7:0] data_s1;

	// Space when empty or when the held byte moves on this cycle.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= rx_byte;
		end
	end

	assign item.valid = valid_s1;
	assign item.data  = data_s1;

endmodule

// ----- rtl/mrfc_frame_core.sv -----
// Frame tracking, running CRC and the result register.
`timescale 1ns / 1ps

module mrfc_frame_core import mrfc_pkg::*; #(
	parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  mrfc_item_t item,
	output logic       advance,
	input  logic [7:0] addr_match,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] node_address,
	output logic [7:0] data_first,
	output logic [7:0] data_second,
	output logic       crc_ok
);

	localparam int POS_W = $clog2(FRAME_LENGTH);
	localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FRAME_LENGTH - 1);
	localparam logic [POS_W-1:0] CRC_LO_POS = POS_W'(FRAME_LENGTH - 2);
	localparam logic [POS_W-1:0] DATA1_POS  = POS_W'(3);
	localparam logic [POS_W-1:0] DATA2_POS  = POS_W'(4);

	logic             in_frame_q;
	logic [POS_W-1:0] pos_q;
	logic [15:0]      crc_q;
	logic [7:0]       addr_q;
	logic [7:0]       data1_q;
	logic [7:0]       data2_q;
	logic [7:0]       crc_lo_q;
	logic             out_valid_q;

	logic [7:0]  b;
	logic [15:0] crc_next;
	logic        is_last;
	logic        emit;

	assign b        = item.data;
	assign crc_next = crc_update(in_frame_q ? crc_q : CRC_INIT, b);
	assign is_last  = in_frame_q && (pos_q == LAST_POS);

	// Only the last byte of a frame needs room in the result register; every other
	// byte moves on even while a result is waiting.
	assign advance = item.valid && (!is_last || !out_valid_q || out_ready);
	assign emit    = advance && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				if (!in_frame_q) begin
					if (b == addr_match) begin
						in_frame_q <= 1'b1;
						pos_q      <= POS_W'(1);
					end
				end else if (is_last) begin
					in_frame_q <= 1'b0;
					pos_q      <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (!in_frame_q) begin
				addr_q <= b;
				crc_q  <= crc_next;
			end else begin
				if (pos_q == DATA1_POS) begin
					data1_q <= b;
				end
				if (pos_q == DATA2_POS) begin
					data2_q <= b;
				end
				if (pos_q < CRC_LO_POS) begin
					crc_q <= crc_next;
				end else if (pos_q == CRC_LO_POS) begin
					crc_lo_q <= b;
				end
			end
		end
		if (emit) begin
			node_address <= addr_q;
			data_first   <= data1_q;
			data_second  <= (pos_q == DATA2_POS) ? b : data2_q;
			crc_ok       <= (crc_lo_q == crc_q[7:0]) && (b == crc_q[15:8]);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/modbus_response_frame_checker.sv -----
// Top level of the Modbus RTU response frame checker.
//
//   Channel  | Handshake                 | Payload
//   ---------+---------------------------+-------------------------------------------
//   input    | in_valid / in_ready       | rx_byte
//   result   | out_valid / out_ready     | node_address, data_first, data_second, crc_ok
//   config   | cfg_write_en              | cfg_write_data (expected slave address)
//
// A byte is held in the input register while the CRC byte update works on it; when the
// last byte of a frame leaves that register it loads the result register, which drives
// out_valid. One byte is accepted per cycle while no waiting result stalls the input.
// Reset is asynchronous and active low; it returns the block to hunting for the address
// and sets the expected address to 1. A result that is not taken stalls only the last byte
// of the following frame: it waits in the input register, and in_ready falls, until the
// result transfer is made.
`timescale 1ns / 1ps

module modbus_response_frame_checker import mrfc_pkg::*; #(
	parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] node_address,
	output logic [7:0] data_first,
	output logic [7:0] data_second,
	output logic       crc_ok,
	input  logic       cfg_write_en,
	input  logic [7:0] cfg_write_data
);

	mrfc_item_t item;
	logic       advance;
	logic [7:0] expected_address_q;

	// The address only steers hunting; the user must write it only while idle (unenforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_address_q <= ADDR_RESET;
		end else if (cfg_write_en) begin
			expected_address_q <= cfg_write_data;
		end
	end

	// The input register decouples the sender from a stalled result.
	mrfc_input_stage u_input (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.item     (item)
	);

	// The core tracks the frame position, folds each byte but the two CRC bytes into the
	// CRC and, on the last byte of the frame, loads the result register with the address,
	// two data bytes and the outcome of the CRC comparison.
	mrfc_frame_core #(
		.FRAME_LENGTH (FRAME_LENGTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.advance      (advance),
		.addr_match   (expected_address_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.node_address (node_address),
		.data_first   (data_first),
		.data_second  (data_second),
		.crc_ok       (crc_ok)
	);

endmodule

// ----- rtl/mrfc_checker.sv -----
// Port-level assertions for the response frame checker, bound to the top level.
`timescale 1ns / 1ps

module mrfc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] node_address,
	input logic [7:0] data_first,
	input logic [7:0] data_second,
	input logic       crc_ok
);

	// A result that is not taken stays with its payload unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(node_address) &&
			$stable(data_first) && $stable(data_second) && $stable(crc_ok))
		else $error("result changed before its transfer");

	// The input side only stalls behind a waiting result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");

	// A new result appears only after the input side has moved.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_ready))
		else $error("result appeared without the input register moving");

endmodule

bind modbus_response_frame_checker mrfc_checker u_mrfc_checker (.*);
